### hw/rtl/clmd_pkg.sv
// Shared types and constants for the content-length message deframer.
package clmd_pkg;

	// Line store size; the last two places are kept for CR LF
	localparam int LINE_STORE_BYTES = 80;
	localparam int CONTENT_LIMIT = LINE_STORE_BYTES - 2;
	localparam int POS_W = $clog2(CONTENT_LIMIT + 1);

	// Length field: digit count saturates one above the limit
	localparam int MAX_LENGTH_DIGITS = 7;
	localparam int DIGIT_W = $clog2(MAX_LENGTH_DIGITS + 2);
	localparam int LEN_W = $clog2(10 ** MAX_LENGTH_DIGITS);

	// Header key "Content-Length"
	localparam int KEY_LEN = 14;
	localparam int KEY_W = $clog2(KEY_LEN + 1);

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [1:0] {
		KIND_BODY = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_HDR_ERR = 2'd2,
		KIND_CLOSED = 2'd3
	} kind_t;

	typedef enum logic {
		PH_HEADER = 1'b0,
		PH_BODY = 1'b1
	} phase_t;

	// Per-line parse state
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [KEY_W-1:0] key_idx;
		logic key_match;
		logic seen_colon;
		logic skip_sp;
		logic [DIGIT_W-1:0] digits;
		logic value_bad;
		logic [LEN_W-1:0] acc;
	} line_t;

	localparam line_t LINE_CLEAR = '{
		pos: '0,
		key_idx: '0,
		key_match: 1'b1,
		seen_colon: 1'b0,
		skip_sp: 1'b0,
		digits: '0,
		value_bad: 1'b0,
		acc: '0
	};

endpackage

### hw/rtl/content_length_message_deframer.sv
// Top level: content-length framed message deframer, one byte per cycle while in_stall is low.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------
//  in      | in_valid/in_stall  | data_byte, link_closed
//  out     | out_valid/out_stall| result_kind, body_byte, last_byte
//
// One request is taken per cycle while in_stall is low; each passes an input
// register and the combinational parse logic into the output register.
// The rate is set by the parse update of the line state, which is combinational.
// arst_n clears the parse state and both valid flags.
// in_stall rises only while a result is held and out_stall is high;
// a request that gives no result still waits for the output slot.
module content_length_message_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       link_closed,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] result_kind,
	output logic [7:0] body_byte,
	output logic       last_byte
);

	// Key character at a match position
	function automatic logic [7:0] key_char(input logic [clmd_pkg::KEY_W-1:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0: c = 8'h43; // C
			4'd1: c = 8'h6f; // o
			4'd2: c = 8'h6e; // n
			4'd3: c = 8'h74; // t
			4'd4: c = 8'h65; // e
			4'd5: c = 8'h6e; // n
			4'd6: c = 8'h74; // t
			4'd7: c = 8'h2d; // -
			4'd8: c = 8'h4c; // L
			4'd9: c = 8'h65; // e
			4'd10: c = 8'h6e; // n
			4'd11: c = 8'h67; // g
			4'd12: c = 8'h74; // t
			4'd13: c = 8'h68; // h
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// One content byte applied to the line state
	function automatic clmd_pkg::line_t content_step(input clmd_pkg::line_t ln,
		input logic [7:0] b);
		clmd_pkg::line_t r;
		logic [clmd_pkg::LEN_W+3:0] prod;
		r = ln;
		prod = ({4'b0, ln.acc} << 3) + ({4'b0, ln.acc} << 1)
			+ (clmd_pkg::LEN_W + 4)'(b - clmd_pkg::CH_ZERO);
		if (ln.pos < clmd_pkg::POS_W'(clmd_pkg::CONTENT_LIMIT)) begin
			r.pos = ln.pos + 1'b1;
			if (!ln.seen_colon) begin
				if (b == clmd_pkg::CH_COLON) begin
					r.seen_colon = 1'b1;
					r.skip_sp = 1'b1;
				end else if (ln.key_match
					&& ln.key_idx < clmd_pkg::KEY_W'(clmd_pkg::KEY_LEN)
					&& b == key_char(ln.key_idx)) begin
					r.key_idx = ln.key_idx + 1'b1;
				end else begin
					r.key_match = 1'b0;
				end
			end else if (!(ln.skip_sp && b == clmd_pkg::CH_SPACE)) begin
				r.skip_sp = 1'b0;
				if (ln.digits <= clmd_pkg::DIGIT_W'(clmd_pkg::MAX_LENGTH_DIGITS))
					r.digits = ln.digits + 1'b1;
				if (b < clmd_pkg::CH_ZERO || b > clmd_pkg::CH_NINE)
					r.value_bad = 1'b1;
				else if (r.digits <= clmd_pkg::DIGIT_W'(clmd_pkg::MAX_LENGTH_DIGITS))
					r.acc = prod[clmd_pkg::LEN_W-1:0];
			end
		end
		return r;
	endfunction

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       closed_s1;

	// Parse state
	clmd_pkg::phase_t phase_q, phase_d;
	clmd_pkg::line_t line_q, line_d;
	logic pending_cr_q, pending_cr_d;
	logic [clmd_pkg::LEN_W-1:0] remain_q, remain_d;

	// Output register
	logic             out_valid_q;
	clmd_pkg::kind_t  kind_q;
	logic [7:0]       body_q;
	logic             last_q;

	// Result of the current request
	logic            res_valid;
	clmd_pkg::kind_t res_kind;
	logic [7:0]      res_body;
	logic            res_last;

	logic adv;
	logic key_hit;
	clmd_pkg::line_t ln_tmp;

	assign adv = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= data_byte;
			closed_s1 <= link_closed;
		end
	end

	// Parse update for the request in the input register
	always_comb begin
		phase_d = phase_q;
		line_d = line_q;
		pending_cr_d = pending_cr_q;
		remain_d = remain_q;
		res_valid = 1'b0;
		res_kind = clmd_pkg::KIND_BODY;
		res_body = 8'h00;
		res_last = 1'b0;
		key_hit = line_q.key_match
			&& line_q.key_idx == clmd_pkg::KEY_W'(clmd_pkg::KEY_LEN);
		ln_tmp = line_q;
		priority if (closed_s1) begin
			// link closed: full restart
			phase_d = clmd_pkg::PH_HEADER;
			line_d = clmd_pkg::LINE_CLEAR;
			pending_cr_d = 1'b0;
			remain_d = '0;
			res_valid = 1'b1;
			res_kind = clmd_pkg::KIND_CLOSED;
		end else if (phase_q == clmd_pkg::PH_BODY && remain_q != '0) begin
			// body byte passes out
			res_valid = 1'b1;
			res_kind = clmd_pkg::KIND_BODY;
			res_body = byte_s1;
			res_last = (remain_q == clmd_pkg::LEN_W'(1));
			remain_d = remain_q - 1'b1;
			if (res_last) begin
				phase_d = clmd_pkg::PH_HEADER;
				line_d = clmd_pkg::LINE_CLEAR;
				pending_cr_d = 1'b0;
			end
		end else if (byte_s1 == clmd_pkg::CH_LF && pending_cr_q) begin
			// end of line
			phase_d = clmd_pkg::PH_HEADER;
			pending_cr_d = 1'b0;
			line_d = clmd_pkg::LINE_CLEAR;
			if (line_q.pos == '0) begin
				if (remain_q == '0) begin
					res_valid = 1'b1;
					res_kind = clmd_pkg::KIND_EMPTY;
				end else begin
					phase_d = clmd_pkg::PH_BODY;
				end
			end else if (key_hit) begin
				if (!line_q.seen_colon || line_q.value_bad
					|| line_q.digits > clmd_pkg::DIGIT_W'(clmd_pkg::MAX_LENGTH_DIGITS)) begin
					res_valid = 1'b1;
					res_kind = clmd_pkg::KIND_HDR_ERR;
					remain_d = '0;
				end else begin
					remain_d = line_q.acc;
				end
			end
		end else begin
			// ordinary byte; a held CR counts as content first
			phase_d = clmd_pkg::PH_HEADER;
			if (pending_cr_q)
				ln_tmp = content_step(line_q, clmd_pkg::CH_CR);
			if (byte_s1 == clmd_pkg::CH_CR) begin
				pending_cr_d = 1'b1;
				line_d = ln_tmp;
			end else begin
				pending_cr_d = 1'b0;
				line_d = content_step(ln_tmp, byte_s1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= clmd_pkg::PH_HEADER;
			line_q <= clmd_pkg::LINE_CLEAR;
			pending_cr_q <= 1'b0;
			remain_q <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && res_valid;
			if (valid_s1) begin
				phase_q <= phase_d;
				line_q <= line_d;
				pending_cr_q <= pending_cr_d;
				remain_q <= remain_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q <= res_kind;
			body_q <= res_body;
			last_q <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = kind_q;
	assign body_byte = body_q;
	assign last_byte = last_q;

endmodule

### hw/rtl/clmd_checker.sv
// Port-level checks for the deframer and their bind to the top level.
module clmd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] result_kind,
	input logic [7:0] body_byte,
	input logic       link_closed,
	input logic       last_byte
);

	// input backs up only behind a held, stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled result");

	// last mark only on a body byte
	a_last_body: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_byte) |-> (result_kind == clmd_pkg::KIND_BODY))
		else $error("last mark on a non-body result");

	// non-body results carry a zero byte
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind != clmd_pkg::KIND_BODY) |-> (body_byte == 8'h00))
		else $error("non-body result with a byte");

	// link close gives a closed result through the input and output registers, when nothing stalls
	a_close_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && link_closed && !out_valid) ##1 !in_stall
		|=> (out_valid && result_kind == clmd_pkg::KIND_CLOSED))
		else $error("close request without closed result");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(result_kind)
			&& $stable(body_byte) && $stable(last_byte)))
		else $error("stalled result changed");

endmodule

bind content_length_message_deframer clmd_checker u_clmd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.result_kind(result_kind),
	.body_byte(body_byte),
	.link_closed(link_closed),
	.last_byte(last_byte)
);

### bench/content_length_message_deframer_test.sv
// Self-checking bench for the content-length message deframer: directed and random traffic.
`timescale 1ns / 1ps

module content_length_message_deframer_test;
	import clmd_pkg::*;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} frame_out_t;

	localparam logic [8*KEY_LEN-1:0] HDR_KEY = "Content-Length";

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       link_closed = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] result_kind;
	logic [7:0] body_byte;
	logic       last_byte;

	content_length_message_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.link_closed(link_closed),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.body_byte(body_byte),
		.last_byte(last_byte)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Deframer state mirror
	phase_t             frame_phase;
	logic [POS_W-1:0]   line_pos;
	logic               cr_held;
	logic [KEY_W-1:0]   key_idx;
	logic               key_ok;
	logic               colon_seen;
	logic               skip_sp;
	logic [DIGIT_W-1:0] ndigits;
	logic               val_bad;
	logic [LEN_W-1:0]   len_acc;
	logic [LEN_W-1:0]   body_left;

	frame_out_t pending_results[$];
	logic [8:0] stream_q[$];   // bit 8 marks a link-closed request
	int         idle_pct = 0;
	int         stall_pct = 0;
	int         sent_items = 0;
	int         fail_count = 0;

	function automatic void clear_line();
		line_pos = '0;
		cr_held = 1'b0;
		key_idx = '0;
		key_ok = 1'b1;
		colon_seen = 1'b0;
		skip_sp = 1'b0;
		ndigits = '0;
		val_bad = 1'b0;
		len_acc = '0;
	endfunction

	function automatic void clear_message();
		clear_line();
		frame_phase = PH_HEADER;
		body_left = '0;
	endfunction

	// One content byte of a header line: key match, colon, value digits
	function automatic void parse_content(input logic [7:0] b);
		if (line_pos >= CONTENT_LIMIT)
			return;
		line_pos = line_pos + 1'b1;
		if (!colon_seen) begin
			if (b == CH_COLON) begin
				colon_seen = 1'b1;
				skip_sp = 1'b1;
			end else if (key_ok && key_idx < KEY_LEN &&
					b == HDR_KEY[8*(KEY_LEN-1-key_idx) +: 8]) begin
				key_idx = key_idx + 1'b1;
			end else begin
				key_ok = 1'b0;
			end
			return;
		end
		if (skip_sp && b == CH_SPACE)
			return;
		skip_sp = 1'b0;
		if (ndigits <= MAX_LENGTH_DIGITS)
			ndigits = ndigits + 1'b1;
		if (b < CH_ZERO || b > CH_NINE)
			val_bad = 1'b1;
		else if (ndigits <= MAX_LENGTH_DIGITS)
			len_acc = LEN_W'(len_acc * 10 + (b - CH_ZERO));
	endfunction

	// CR LF seen: empty line ends headers; a Content-Length line latches length or flags an error
	function automatic bit finish_line(inout frame_out_t r);
		if (line_pos == 0) begin
			if (body_left == 0) begin
				clear_message();
				r.kind = KIND_EMPTY;
				return 1'b1;
			end
			clear_line();
			frame_phase = PH_BODY;
			return 1'b0;
		end
		if (key_ok && key_idx == KEY_LEN) begin
			if (!colon_seen || val_bad || ndigits > MAX_LENGTH_DIGITS) begin
				clear_message();
				r.kind = KIND_HDR_ERR;
				return 1'b1;
			end
			body_left = len_acc;
		end
		clear_line();
		return 1'b0;
	endfunction

	function automatic bit predict_request(input logic [7:0] b, input logic closed,
			output frame_out_t r);
		r = '{kind: KIND_BODY, data: 8'h00, last: 1'b0};
		if (closed) begin
			clear_message();
			r.kind = KIND_CLOSED;
			return 1'b1;
		end
		if (frame_phase == PH_BODY && body_left != 0) begin
			r.data = b;
			r.last = (body_left == 1);
			body_left = body_left - 1'b1;
			if (body_left == 0)
				clear_message();
			return 1'b1;
		end
		frame_phase = PH_HEADER;
		if (b == CH_LF && cr_held) begin
			cr_held = 1'b0;
			return finish_line(r);
		end
		if (cr_held) begin
			parse_content(CH_CR);
			cr_held = 1'b0;
		end
		if (b == CH_CR)
			cr_held = 1'b1;
		else
			parse_content(b);
		return 1'b0;
	endfunction

	// Receiver stall
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// Result check; signals are stable at the falling edge
	always @(negedge clk) begin
		frame_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result_kind: expected no result, got %0d", result_kind);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_kind !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
					fail_count++;
				end
				if (body_byte !== want.data) begin
					$error("body_byte: expected %02h, got %02h", want.data, body_byte);
					fail_count++;
				end
				if (last_byte !== want.last) begin
					$error("last_byte: expected %0b, got %0b", want.last, last_byte);
					fail_count++;
				end
			end
		end
	end

	// Drive one request and wait for it to be taken
	task automatic send_req(input logic [7:0] b, input logic closed);
		frame_out_t r;
		bit         taken;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		link_closed <= closed;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		sent_items++;
		if (predict_request(b, closed, r))
			pending_results.push_back(r);
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic add_byte(input logic [7:0] b);
		stream_q.push_back({1'b0, b});
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_crlf();
		add_byte(CH_CR);
		add_byte(CH_LF);
	endtask

	task automatic add_line(input string s);
		add_text(s);
		add_crlf();
	endtask

	task automatic add_close();
		stream_q.push_back({1'b1, 8'($urandom_range(255))});
	endtask

	task automatic play_stream();
		logic [8:0] item;
		while (stream_q.size() != 0) begin
			item = stream_q.pop_front();
			send_req(item[7:0], item[8]);
		end
	endtask

	// Header line that is not Content-Length, occasionally with raw bytes
	task automatic add_junk_header();
		add_text("X-");
		repeat ($urandom_range(1, 20)) begin
			if ($urandom_range(9) == 0)
				add_byte(8'($urandom_range(255)));
			else
				add_byte(8'($urandom_range(32, 126)));
		end
		add_crlf();
	endtask

	task automatic test_message_framing();
		add_line("Host: x");
		add_line("Content-Length: 3");
		add_crlf();
		add_byte(8'h00);
		add_byte(8'hff);
		add_byte(8'ha5);
		// zero length, then an empty value
		add_line("Content-Length: 0");
		add_crlf();
		add_line("Content-Length:");
		add_crlf();
		// spaces skipped, seven digits with leading zeros
		add_line("Content-Length:    0000002");
		add_crlf();
		add_text("ok");
		play_stream();
	endtask

	task automatic test_header_cases();
		// repeated length: the later one wins
		add_line("Content-Length: 9999999");
		add_line("Content-Length: 2");
		add_crlf();
		add_text("ab");
		// lone CR inside a header and as a body byte
		add_text("X-A: a");
		add_byte(CH_CR);
		add_text("b");
		add_crlf();
		add_line("Content-Length:1");
		add_crlf();
		add_byte(CH_CR);
		// NUL in a header
		add_byte(8'h00);
		add_text(": ");
		add_byte(8'h00);
		add_crlf();
		add_crlf();
		// long line: colon beyond the line limit is dropped
		add_text("Content-Length");
		repeat (CONTENT_LIMIT - KEY_LEN) add_byte(CH_SPACE);
		add_line(": 5");
		play_stream();
		wait_quiet();
	endtask

	task automatic test_header_errors();
		add_line("Content-Length 5");
		add_line("Content-Length: 12345678");
		add_line("Content-Length: 1x");
		add_line("Content-Length: 12 ");
		add_line("content-length: 4");
		add_crlf();
		play_stream();
	endtask

	task automatic test_link_closed();
		add_close();
		add_text("Content-Len");
		add_close();
		add_line("Content-Length: 9999999");
		add_crlf();
		add_byte(8'h5a);
		add_byte(8'ha5);
		add_close();
		play_stream();
		wait_quiet();
	endtask

	// One well-formed message or a piece of noise
	task automatic gen_message();
		int len;
		int cut;
		logic [7:0] b;
		if ($urandom_range(99) < 72) begin
			repeat ($urandom_range(2)) add_junk_header();
			if ($urandom_range(5) == 0)
				add_line("Content-Length: 12");
			len = ($urandom_range(7) == 0) ? $urandom_range(90) : $urandom_range(12);
			add_text("Content-Length:");
			repeat ($urandom_range(3)) add_byte(CH_SPACE);
			if (len != 0 || $urandom_range(1)) begin
				repeat ($urandom_range(4)) add_byte(CH_ZERO);
				add_text($sformatf("%0d", len));
			end
			add_crlf();
			if ($urandom_range(2) == 0)
				add_junk_header();
			add_crlf();
			cut = len;
			if (len != 0 && $urandom_range(19) == 0)
				cut = $urandom_range(len - 1);
			repeat (cut) add_byte(8'($urandom_range(255)));
			if (cut < len)
				add_close();
		end else begin
			case ($urandom_range(6))
				0: begin
					repeat ($urandom_range(1, 30)) add_byte(8'($urandom_range(255)));
					add_crlf();
				end
				1: begin
					add_text("Content-Length");
					repeat ($urandom_range(3)) add_byte(8'(CH_ZERO + $urandom_range(9)));
					add_crlf();
				end
				2: begin
					add_text("Content-Length: ");
					repeat ($urandom_range(8, 9))
						add_byte(8'(CH_ZERO + $urandom_range(9)));
					add_crlf();
				end
				3: begin
					add_text("Content-Length: ");
					repeat ($urandom_range(3)) add_byte(8'(CH_ZERO + $urandom_range(9)));
					b = 8'($urandom_range(255));
					if (b >= CH_ZERO && b <= CH_NINE)
						b = ~b;
					add_byte(b);
					add_crlf();
				end
				4: begin
					repeat ($urandom_range(CONTENT_LIMIT + 1, 100))
						add_byte(8'($urandom_range(32, 126)));
					add_crlf();
				end
				5: add_close();
				default: begin
					add_byte(CH_LF);
					add_byte(CH_CR);
					add_text("A");
					add_crlf();
					add_crlf();
				end
			endcase
		end
	endtask

	task automatic test_random_traffic();
		int idle_by_phase[4] = '{0, 47, 0, 11};
		int stall_by_phase[4] = '{0, 0, 47, 11};
		int start;
		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_by_phase[p];
			stall_pct = stall_by_phase[p];
			start = sent_items;
			while (sent_items - start < 160) begin
				gen_message();
				play_stream();
			end
			wait_quiet();
		end
	endtask

	initial begin
		clear_message();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_message_framing();
		test_header_cases();
		test_header_errors();
		test_link_closed();
		test_random_traffic();
		wait_quiet();
		if (fail_count == 0)
			$display("content_length_message_deframer_test: clean");
		else
			$display("content_length_message_deframer_test: errors");
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("content_length_message_deframer_test: errors");
		$finish;
	end

endmodule
